// ===== hdl/sgr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square grid rotator package
// Shared constants, opcode codes and the command type passed from the front
// end to the execution back end.
// ----------------------------------------------------------------------------
package sgr_pkg;

	localparam int DEF_GRID_SIDE = 16;
	localparam int CMD_DEPTH     = 2;

	localparam int OPCODE_W = 3;
	localparam int INDEX_W  = 4;
	localparam int CELL_W   = 8;
	localparam int DIM_W    = 5;

	localparam int S_TDATA_W = 32;
	localparam int S_TUSER_W = OPCODE_W;
	localparam int M_TDATA_W = 24;

	localparam logic [CELL_W-1:0] BLANK_CELL = 8'h20;

	localparam logic [OPCODE_W-1:0] OP_SET_DIMS = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_WRITE    = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_ROT_CW   = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_ROT_CCW  = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_READ     = 3'd4;

	typedef enum logic [2:0] {
		KIND_SET_DIMS,
		KIND_WRITE,
		KIND_ROT_CW,
		KIND_ROT_CCW,
		KIND_REPORT
	} sgr_kind_t;

	typedef struct packed {
		sgr_kind_t            kind;
		logic                 in_grid;
		logic [INDEX_W-1:0]   row;
		logic [INDEX_W-1:0]   col;
		logic [CELL_W-1:0]    value;
		logic [DIM_W-1:0]     width;
		logic [DIM_W-1:0]     height;
	} sgr_cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ROT_RD,
		ST_ROT_MID,
		ST_ROT_WR,
		ST_ROT_END,
		ST_FETCH,
		ST_RESULT
	} sgr_state_t;

endpackage

// ===== hdl/sgr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module sgr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/sgr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square grid rotator front end
// Takes input transfers, decodes the opcode and checks the cell address.
// ----------------------------------------------------------------------------
module sgr_front
	import sgr_pkg::*;
#(
	parameter int GRID_SIDE = DEF_GRID_SIDE
) (
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic [S_TUSER_W-1:0] s_tuser,
	input  logic                 clearing,
	output logic                 cmd_valid,
	input  logic                 cmd_ready,
	output sgr_cmd_t             cmd
);

	sgr_kind_t kind;

	always_comb begin
		case (s_tuser)
			OP_SET_DIMS: kind = KIND_SET_DIMS;
			OP_WRITE:    kind = KIND_WRITE;
			OP_ROT_CW:   kind = KIND_ROT_CW;
			OP_ROT_CCW:  kind = KIND_ROT_CCW;
			OP_READ:     kind = KIND_REPORT;
			default:     kind = KIND_REPORT;
		endcase
	end

	always_comb begin
		cmd.kind    = kind;
		cmd.row     = s_tdata[3:0];
		cmd.col     = s_tdata[7:4];
		cmd.value   = s_tdata[15:8];
		cmd.width   = s_tdata[20:16];
		cmd.height  = s_tdata[25:21];
		cmd.in_grid = (int'(s_tdata[3:0]) < GRID_SIDE) && (int'(s_tdata[7:4]) < GRID_SIDE);
	end

	assign s_tready  = cmd_ready && !clearing;
	assign cmd_valid = s_tvalid && !clearing;

endmodule

// ===== hdl/sgr_cmd_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square grid rotator command queue
// Short queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module sgr_cmd_fifo
	import sgr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  sgr_cmd_t in_cmd,
	output logic     out_valid,
	input  logic     out_ready,
	output sgr_cmd_t out_cmd
);

	localparam int PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
	localparam int CNT_W = $clog2(CMD_DEPTH + 1);

	sgr_cmd_t           entry_q [CMD_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               push;
	logic               pop;

	assign in_ready  = (cnt_q != CNT_W'(CMD_DEPTH));
	assign out_valid = (cnt_q != '0);
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/sgr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square grid rotator back end
// Holds the cell store, the scratch store and the shape size, runs the
// rotation sweeps and drives the result register.
// ----------------------------------------------------------------------------
module sgr_back
	import sgr_pkg::*;
#(
	parameter int GRID_SIDE = DEF_GRID_SIDE
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_ready,
	input  sgr_cmd_t             cmd,
	output logic                 clearing,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata
);

	localparam int CELLS = GRID_SIDE * GRID_SIDE;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = $clog2(GRID_SIDE);
	localparam int SW    = $clog2(GRID_SIDE + 1);

	sgr_state_t        state_q;
	sgr_state_t        state_d;
	sgr_cmd_t          cmd_q;
	logic [DIM_W-1:0]  width_q;
	logic [DIM_W-1:0]  height_q;
	logic [SW-1:0]     side_q;
	logic [CW-1:0]     r_q;
	logic [CW-1:0]     c_q;
	logic [AW-1:0]     clr_q;
	logic              pipe_vld_s1;
	logic              pipe_to_cell_s1;
	logic [AW-1:0]     pipe_addr_s1;
	logic              m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	logic [DIM_W-1:0]  max_dim;
	logic [SW-1:0]     side_new;
	logic              last_elem;
	logic [AW-1:0]     sq_addr;
	logic [AW-1:0]     src_addr;
	logic [AW-1:0]     head_addr;
	logic [AW-1:0]     cmd_addr;
	logic              pop;
	logic              step;
	logic              load_out;
	logic              cell_we;
	logic [AW-1:0]     cell_wa;
	logic [CELL_W-1:0] cell_wd;
	logic              cell_re;
	logic [AW-1:0]     cell_ra;
	logic [CELL_W-1:0] cell_rd;
	logic              scr_we;
	logic              scr_re;
	logic [CELL_W-1:0] scr_rd;
	logic [CELL_W-1:0] cell_res;

	assign max_dim   = (width_q > height_q) ? width_q : height_q;
	assign side_new  = (int'(max_dim) > GRID_SIDE) ? SW'(GRID_SIDE) : SW'(max_dim);
	assign last_elem = (int'(r_q) == int'(side_q) - 1) && (int'(c_q) == int'(side_q) - 1);
	assign sq_addr   = AW'(int'(r_q) * GRID_SIDE + int'(c_q));
	assign head_addr = AW'(int'(cmd.row) * GRID_SIDE + int'(cmd.col));
	assign cmd_addr  = AW'(int'(cmd_q.row) * GRID_SIDE + int'(cmd_q.col));

	always_comb begin
		if (cmd_q.kind == KIND_ROT_CW) begin
			src_addr = AW'((int'(side_q) - 1 - int'(c_q)) * GRID_SIDE + int'(r_q));
		end else begin
			src_addr = AW'(int'(c_q) * GRID_SIDE + (int'(side_q) - 1 - int'(r_q)));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		step     = 1'b0;
		load_out = 1'b0;
		cell_we  = pipe_vld_s1 && pipe_to_cell_s1;
		cell_wa  = pipe_addr_s1;
		cell_wd  = scr_rd;
		cell_re  = 1'b0;
		cell_ra  = cmd_addr;
		scr_re   = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cell_we = 1'b1;
				cell_wa = clr_q;
				cell_wd = BLANK_CELL;
				if (clr_q == AW'(CELLS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (cmd_valid) begin
					pop     = 1'b1;
					state_d = ST_FETCH;
					case (cmd.kind)
						KIND_ROT_CW, KIND_ROT_CCW: begin
							if (side_new != '0) begin
								state_d = ST_ROT_RD;
							end
						end
						KIND_WRITE: begin
							if (cmd.in_grid) begin
								cell_we = 1'b1;
								cell_wa = head_addr;
								cell_wd = cmd.value;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_ROT_RD: begin
				cell_re = 1'b1;
				cell_ra = src_addr;
				step    = 1'b1;
				if (last_elem) begin
					state_d = ST_ROT_MID;
				end
			end
			ST_ROT_MID: begin
				state_d = ST_ROT_WR;
			end
			ST_ROT_WR: begin
				scr_re = 1'b1;
				step   = 1'b1;
				if (last_elem) begin
					state_d = ST_ROT_END;
				end
			end
			ST_ROT_END: begin
				state_d = ST_FETCH;
			end
			ST_FETCH: begin
				cell_re = 1'b1;
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (!m_tvalid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign scr_we    = pipe_vld_s1 && !pipe_to_cell_s1;
	assign cmd_ready = pop;
	assign clearing  = (state_q == ST_CLEAR);
	assign cell_res  = cmd_q.in_grid ? cell_rd : BLANK_CELL;

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= cmd;
		end
		pipe_addr_s1 <= sq_addr;
		if (load_out) begin
			m_tdata_q <= {6'd0, height_q, width_q, cell_res};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q         <= DIM_W'(1);
			height_q        <= DIM_W'(1);
			side_q          <= '0;
			r_q             <= '0;
			c_q             <= '0;
			clr_q           <= '0;
			pipe_vld_s1     <= 1'b0;
			pipe_to_cell_s1 <= 1'b0;
			m_tvalid_q      <= 1'b0;
		end else begin
			pipe_vld_s1     <= (state_q == ST_ROT_RD) || (state_q == ST_ROT_WR);
			pipe_to_cell_s1 <= (state_q == ST_ROT_WR);
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (pop) begin
				r_q <= '0;
				c_q <= '0;
				case (cmd.kind)
					KIND_SET_DIMS: begin
						width_q  <= cmd.width;
						height_q <= cmd.height;
					end
					KIND_ROT_CW, KIND_ROT_CCW: begin
						side_q   <= side_new;
						width_q  <= height_q;
						height_q <= width_q;
					end
					default: begin
					end
				endcase
			end else if (step) begin
				if (last_elem) begin
					r_q <= '0;
					c_q <= '0;
				end else if (int'(c_q) == int'(side_q) - 1) begin
					c_q <= '0;
					r_q <= r_q + 1'b1;
				end else begin
					c_q <= c_q + 1'b1;
				end
			end
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	sgr_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELLS)
	) u_cell_ram (
		.clk  (clk),
		.we   (cell_we),
		.waddr(cell_wa),
		.wdata(cell_wd),
		.re   (cell_re),
		.raddr(cell_ra),
		.rdata(cell_rd)
	);

	sgr_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELLS)
	) u_scratch_ram (
		.clk  (clk),
		.we   (scr_we),
		.waddr(pipe_addr_s1),
		.wdata(cell_rd),
		.re   (scr_re),
		.raddr(sq_addr),
		.rdata(scr_rd)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ===== hdl/square_grid_rotator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square grid rotator
// Square character store with a shape size; sets dimensions, writes, reads
// and rotates the top-left square by a quarter turn either way.
// The back end runs one command at a time, while the command queue can
// take new transfers before the last one is through. A rotation is a read
// sweep from the cell store into the scratch store followed by a write
// sweep back into the cell store.
// Reset: width and height return to one, then a clearing pass fills the
// store with spaces; s_tready is low during that pass.
// ----------------------------------------------------------------------------
module square_grid_rotator_unit
	import sgr_pkg::*;
#(
	parameter int GRID_SIDE = DEF_GRID_SIDE
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// row_index[3:0], col_index[7:4], cell_value[15:8], set_width[20:16],
	// set_height[25:21], zero fill above.
	input  logic [S_TDATA_W-1:0] s_tdata,
	// opcode[2:0].
	input  logic [S_TUSER_W-1:0] s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// cell_out[7:0], cur_width[12:8], cur_height[17:13], zero fill above.
	output logic [M_TDATA_W-1:0] m_tdata
);

	sgr_cmd_t front_cmd;
	sgr_cmd_t queue_cmd;
	logic     front_valid;
	logic     front_ready;
	logic     queue_valid;
	logic     queue_ready;
	logic     clearing;

	sgr_front #(
		.GRID_SIDE(GRID_SIDE)
	) u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.clearing (clearing),
		.cmd_valid(front_valid),
		.cmd_ready(front_ready),
		.cmd      (front_cmd)
	);

	sgr_cmd_fifo u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (front_valid),
		.in_ready (front_ready),
		.in_cmd   (front_cmd),
		.out_valid(queue_valid),
		.out_ready(queue_ready),
		.out_cmd  (queue_cmd)
	);

	sgr_back #(
		.GRID_SIDE(GRID_SIDE)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(queue_valid),
		.cmd_ready(queue_ready),
		.cmd      (queue_cmd),
		.clearing (clearing),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
